// ----- design/ipsd_pkg.sv -----
// ----------------------------------------------------------------------------
// ipsd_pkg: shared types and constants for the inverse Park / SVPWM duty core
// Field widths, datapath widths and the radix-2 divider step used by the
// pipelined duty division.
// ----------------------------------------------------------------------------
package ipsd_pkg;

	// port field width (all fields are 16 bit)
	localparam int FIELD_W = 16;

	// sqrt(3)/2 with 16 fraction bits, rounded to nearest
	localparam logic signed [17:0] SQRT3_HALF_Q16 = 18'sd56756;

	// smallest bus voltage used, about 0.01 V in Q8.8
	localparam logic [FIELD_W-1:0] BUS_MIN = 16'd3;

	// inverse Park products and sums
	localparam int PROD_W = 32;
	localparam int AB_W   = 33;
	localparam int BK_W   = 50;
	// phase voltages with 38 fraction bits
	localparam int PH_W   = 52;
	// doubled, injected phase voltage
	localparam int P_W    = 56;
	// divider dividend: clamped phase shifted down by 16
	localparam int N_W    = 32;

	// divider: 16 quotient bits, a fixed number retired per stage
	localparam int QUO_W      = 16;
	localparam int DIV_BITS   = 2;
	localparam int DIV_STAGES = QUO_W / DIV_BITS;

	// number of phases
	localparam int NUM_PH = 3;

	// partial division state carried between divider stages
	typedef struct packed {
		logic [FIELD_W-1:0] rem;
		logic [FIELD_W-1:0] low;
		logic [QUO_W-1:0]   quo;
	} div_st_t;

	// retire DIV_BITS quotient bits of a restoring division by d
	function automatic div_st_t div_step(div_st_t s, logic [FIELD_W-1:0] d);
		div_st_t         r;
		logic [FIELD_W:0] part;
		logic            qbit;
		r = s;
		for (int i = 0; i < DIV_BITS; i++) begin
			part  = {r.rem, r.low[FIELD_W-1]};
			r.low = {r.low[FIELD_W-2:0], 1'b0};
			qbit  = (part >= {1'b0, d});
			if (qbit) begin
				part = part - {1'b0, d};
			end
			r.rem = part[FIELD_W-1:0];
			r.quo = {r.quo[QUO_W-2:0], qbit};
		end
		return r;
	endfunction

endpackage

// ----- design/ipsd_if.sv -----
// ----------------------------------------------------------------------------
// ipsd channel interfaces
// Valid/ready channels for the voltage command item and the duty item.
// ----------------------------------------------------------------------------
interface ipsd_cmd_if import ipsd_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [FIELD_W-1:0] volt_d;
	logic signed [FIELD_W-1:0] volt_q;
	logic signed [FIELD_W-1:0] angle_sin;
	logic signed [FIELD_W-1:0] angle_cos;
	logic        [FIELD_W-1:0] bus_volt;

	modport source (
		output valid, volt_d, volt_q, angle_sin, angle_cos, bus_volt,
		input  ready
	);
	modport sink (
		input  valid, volt_d, volt_q, angle_sin, angle_cos, bus_volt,
		output ready
	);
endinterface

interface ipsd_duty_if import ipsd_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] duty_u;
	logic [FIELD_W-1:0] duty_v;
	logic [FIELD_W-1:0] duty_w;

	modport source (
		output valid, duty_u, duty_v, duty_w,
		input  ready
	);
	modport sink (
		input  valid, duty_u, duty_v, duty_w,
		output ready
	);
endinterface

// ----- design/inverse_park_svpwm_duty_core.sv -----
// ----------------------------------------------------------------------------
// inverse_park_svpwm_duty_core: d/q voltage command to three PWM duties
// Inverse Park, inverse Clarke, min-max zero-sequence injection, clamp to
// the rails and division by the bus voltage, as a fully pipelined datapath.
// ----------------------------------------------------------------------------
// Usage:
//   cmd  (sink):   one item per PWM update: volt_d, volt_q (Q8.8),
//                  angle_sin, angle_cos (Q1.14), bus_volt (unsigned Q8.8).
//   duty (source): one item per command: duty_u, duty_v, duty_w (Q1.15,
//                  0 to 32768, truncated).
//   Pipeline: 15 register stages from the accepting edge to duty.valid:
//   7 arithmetic stages, then 8 divider stages retiring 2 quotient bits
//   each.
//   Throughput: one item per cycle unless duty stalls; items are independent.
//   The divider pipeline, one restoring subtract per quotient bit, sets
//   the depth; the 33 x 18 bit multiply sets the stage timing.
//   Reset clears all valid bits; no items are in flight afterwards.
//   Stall: while duty.valid is high and duty.ready low the whole pipeline
//   holds and cmd.ready is low; nothing is dropped or repeated. Empty
//   stages do not hold the pipeline back.
// ----------------------------------------------------------------------------
module inverse_park_svpwm_duty_core import ipsd_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	ipsd_cmd_if.sink    cmd,
	ipsd_duty_if.source duty
);

	logic adv;

	// stage 1: products
	logic                      v_s1;
	logic signed [PROD_W-1:0]  p_dc_s1, p_qs_s1, p_ds_s1, p_qc_s1;
	logic        [FIELD_W-1:0] bus_s1;
	// stage 2: alpha / beta
	logic                      v_s2;
	logic signed [AB_W-1:0]    alpha_s2, beta_s2;
	logic        [FIELD_W-1:0] bus_s2;
	// stage 3: beta * sqrt(3)/2
	logic                      v_s3;
	logic signed [AB_W-1:0]    alpha_s3;
	logic signed [BK_W-1:0]    betak_s3;
	logic        [FIELD_W-1:0] bus_s3;
	// stage 4: phase voltages
	logic                      v_s4;
	logic signed [PH_W-1:0]    ph_s4 [NUM_PH];
	logic        [FIELD_W-1:0] bus_s4;
	// stage 5: max / min
	logic                      v_s5;
	logic signed [PH_W-1:0]    ph_s5 [NUM_PH];
	logic signed [PH_W-1:0]    vmax_s5, vmin_s5;
	logic        [FIELD_W-1:0] bus_s5;
	// stage 6: injected, doubled phases
	logic                      v_s6;
	logic signed [P_W-1:0]     pp_s6 [NUM_PH];
	logic        [FIELD_W-1:0] bus_s6;
	// stage 7: clamped dividends
	logic                      v_s7;
	logic        [N_W-1:0]     n_s7 [NUM_PH];
	logic        [FIELD_W-1:0] bus_s7;
	// divider stages, index k is pipeline stage 8 + k
	logic                      div_vld_s [DIV_STAGES];
	div_st_t                   div_s     [DIV_STAGES][NUM_PH];
	logic        [FIELD_W-1:0] div_bus_s [DIV_STAGES];

	// combinational helpers
	logic signed [PH_W-1:0]    va_w, vb_w, vc_w, ah_w, bk_w;
	logic signed [PH_W-1:0]    mx_w, mn_w;
	logic signed [P_W-1:0]     base_w;
	logic signed [P_W-1:0]     top_w;

	// advance the whole pipeline unless a finished item waits
	assign adv       = !duty.valid || duty.ready;
	assign cmd.ready = adv;

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s1 <= cmd.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// stage 1: inverse Park products, clamp the bus voltage
	always_ff @(posedge clk) begin
		if (adv) begin
			p_dc_s1 <= cmd.volt_d * cmd.angle_cos;
			p_qs_s1 <= cmd.volt_q * cmd.angle_sin;
			p_ds_s1 <= cmd.volt_d * cmd.angle_sin;
			p_qc_s1 <= cmd.volt_q * cmd.angle_cos;
			bus_s1  <= (cmd.bus_volt < BUS_MIN) ? BUS_MIN : cmd.bus_volt;
		end
	end

	// stage 2: alpha and beta, 22 fraction bits
	always_ff @(posedge clk) begin
		if (adv) begin
			alpha_s2 <= AB_W'(p_dc_s1) - AB_W'(p_qs_s1);
			beta_s2  <= AB_W'(p_ds_s1) + AB_W'(p_qc_s1);
			bus_s2   <= bus_s1;
		end
	end

	// stage 3: scale beta by sqrt(3)/2
	always_ff @(posedge clk) begin
		if (adv) begin
			alpha_s3 <= alpha_s2;
			betak_s3 <= beta_s2 * SQRT3_HALF_Q16;
			bus_s3   <= bus_s2;
		end
	end

	// stage 4: inverse Clarke, 38 fraction bits
	always_comb begin
		va_w = PH_W'(alpha_s3) <<< 16;
		ah_w = PH_W'(alpha_s3) <<< 15;
		bk_w = PH_W'(betak_s3);
		vb_w = bk_w - ah_w;
		vc_w = -bk_w - ah_w;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ph_s4[0] <= va_w;
			ph_s4[1] <= vb_w;
			ph_s4[2] <= vc_w;
			bus_s4   <= bus_s3;
		end
	end

	// stage 5: largest and smallest phase
	always_comb begin
		mx_w = ph_s4[0];
		if (ph_s4[1] > mx_w) begin
			mx_w = ph_s4[1];
		end
		if (ph_s4[2] > mx_w) begin
			mx_w = ph_s4[2];
		end
		mn_w = ph_s4[0];
		if (ph_s4[1] < mn_w) begin
			mn_w = ph_s4[1];
		end
		if (ph_s4[2] < mn_w) begin
			mn_w = ph_s4[2];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ph_s5   <= ph_s4;
			vmax_s5 <= mx_w;
			vmin_s5 <= mn_w;
			bus_s5  <= bus_s4;
		end
	end

	// stage 6: doubled phase after zero-sequence injection
	assign base_w = $signed(P_W'({bus_s5, 30'd0}));

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int ph = 0; ph < NUM_PH; ph++) begin
				pp_s6[ph] <= (P_W'(ph_s5[ph]) <<< 1) - P_W'(vmax_s5)
					- P_W'(vmin_s5) + base_w;
			end
			bus_s6 <= bus_s5;
		end
	end

	// stage 7: clamp to [0, bus * 2^31], drop 16 bits that never reach the quotient
	assign top_w = $signed(P_W'({bus_s6, 31'd0}));

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int ph = 0; ph < NUM_PH; ph++) begin
				if (pp_s6[ph] < 0) begin
					n_s7[ph] <= '0;
				end else if (pp_s6[ph] > top_w) begin
					n_s7[ph] <= N_W'({bus_s6, 15'd0});
				end else begin
					n_s7[ph] <= pp_s6[ph][N_W+15:16];
				end
			end
			bus_s7 <= bus_s6;
		end
	end

	// stages 8 to 15: restoring division by the bus voltage
	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		logic    vld_in;
		div_st_t st_in [NUM_PH];
		logic [FIELD_W-1:0] bus_in;

		if (k == 0) begin : g_first
			// quotient fits 16 bits, so the upper half is already below bus
			always_comb begin
				vld_in = v_s7;
				bus_in = bus_s7;
				for (int ph = 0; ph < NUM_PH; ph++) begin
					st_in[ph].rem = n_s7[ph][N_W-1:FIELD_W];
					st_in[ph].low = n_s7[ph][FIELD_W-1:0];
					st_in[ph].quo = '0;
				end
			end
		end else begin : g_next
			always_comb begin
				vld_in = div_vld_s[k-1];
				bus_in = div_bus_s[k-1];
				for (int ph = 0; ph < NUM_PH; ph++) begin
					st_in[ph] = div_s[k-1][ph];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_vld_s[k] <= 1'b0;
			end else if (adv) begin
				div_vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				for (int ph = 0; ph < NUM_PH; ph++) begin
					div_s[k][ph] <= div_step(st_in[ph], bus_in);
				end
				div_bus_s[k] <= bus_in;
			end
		end
	end

	// drive the result item from the last divider stage
	assign duty.valid  = div_vld_s[DIV_STAGES-1];
	assign duty.duty_u = div_s[DIV_STAGES-1][0].quo;
	assign duty.duty_v = div_s[DIV_STAGES-1][1].quo;
	assign duty.duty_w = div_s[DIV_STAGES-1][2].quo;

endmodule
